// ----- hdl/vafp_pkg.sv -----
package vafp_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned OCTET_W    = 7;
    localparam int unsigned CHUNK_W    = 6;
    localparam int unsigned SLOT_W     = 4;
    localparam int unsigned PEND_W     = 5;
    localparam int unsigned PCNT_W     = 3;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [SLOT_W-1:0]  SLOT_SYNC  = 4'd0;
    localparam logic [SLOT_W-1:0]  SLOT_FIVE  = 4'd5;
    localparam logic [SLOT_W-1:0]  SLOT_LAST  = 4'd9;

    localparam logic [OCTET_W-1:0] OCT_SYNC  = 7'h00;
    localparam logic [OCTET_W-1:0] OCT_FIVE  = 7'h01;
    localparam logic [OCTET_W-1:0] OCT_FILL  = 7'h7F;

    typedef struct packed {
        logic [CHUNK_W-1:0] d0;
        logic [CHUNK_W-1:0] d1;
        logic [CHUNK_W-1:0] d2;
        logic [1:0]         n_data;
        logic               eom;
    } t_job;

    typedef enum logic {
        ST_DATA,
        ST_FILL
    } t_back_state;

endpackage

// ----- hdl/v110_async_frame_packer_unit.sv -----
// V.110 asynchronous frame packer: each request byte is framed as ten async bits (start,
// eight data LSB first, stop), packed six per octet into ten-octet V.110 frames with
// sync octet 0x00 in slot 0 and 0x01 in slot 5; s_tlast ends the message, padding the
// open octet with ones and filling the rest of the frame with 0x7F outside the header
// slots. A byte request is accepted whenever the job queue (QUEUE_DEPTH entries) has room.
// The output sequencer sends one octet per cycle while the queue holds a job and the output
// is not stalled; a byte yields one to three data octets (the third only for a padded end
// of message) plus any header octets that fall in between, and an end of message then fills
// the frame up to its last slot. m_tlast marks the final octet caused by each input byte.
module v110_async_frame_packer_unit
    import vafp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // data_byte[7:0]
    input  logic       i_s_tlast,   // end_of_message
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // frame_octet[6:0], zero[7]
    output logic       o_m_tlast    // last_of_run
);

    t_job               w_push_job;
    t_job               w_head_job;
    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    logic [OCTET_W-1:0] w_octet;

    vafp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .i_eom   (i_s_tlast),
        .i_full  (w_full),
        .o_ready (o_s_tready),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    vafp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    vafp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_head_job),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_octet (w_octet),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, w_octet};

endmodule

// ----- hdl/vafp_front.sv -----
module vafp_front
    import vafp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_data,
    input  logic              i_eom,
    input  logic              i_full,
    output logic              o_ready,
    output logic              o_push,
    output t_job              o_job
);

    logic [PEND_W-1:0] r_pend_bits, n_pend_bits;
    logic [PCNT_W-1:0] r_pend_cnt, n_pend_cnt;

    logic [14:0]        w_p;
    logic               w_two;
    logic [PEND_W-1:0]  w_rem;
    logic [PCNT_W-1:0]  w_remcnt;
    logic [CHUNK_W-1:0] w_pad;
    logic               w_has_pad;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        w_p = 15'(r_pend_bits) | (15'({1'b1, i_data, 1'b0}) << r_pend_cnt);
        w_two = (r_pend_cnt >= 3'd2);
        if (w_two) begin
            w_rem    = {2'b00, w_p[14:12]};
            w_remcnt = r_pend_cnt - 3'd2;
        end else begin
            w_rem    = w_p[10:6];
            w_remcnt = r_pend_cnt + 3'd4;
        end
        w_pad     = {1'b0, w_rem} | (6'h3F << w_remcnt);
        w_has_pad = i_eom && (w_remcnt != 3'd0);
    end

    always_comb begin
        o_job.d0     = w_p[5:0];
        o_job.d1     = w_two ? w_p[11:6] : w_pad;
        o_job.d2     = w_pad;
        o_job.n_data = 2'd1 + 2'(w_two) + 2'(w_has_pad);
        o_job.eom    = i_eom;
    end

    always_comb begin
        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        if (o_push) begin
            if (i_eom) begin
                n_pend_bits = '0;
                n_pend_cnt  = '0;
            end else begin
                n_pend_bits = w_rem;
                n_pend_cnt  = w_remcnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else begin
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

endmodule

// ----- hdl/vafp_fifo.sv -----
module vafp_fifo
    import vafp_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_wr, w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- hdl/vafp_back.sv -----
module vafp_back
    import vafp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_job               i_job,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [OCTET_W-1:0] o_octet,
    output logic               o_last
);

    t_back_state r_state, n_state;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [1:0]         r_idx, n_idx;
    logic               r_out_valid;
    logic [OCTET_W-1:0] r_out_octet;
    logic               r_out_last;

    logic               w_advance;
    logic               w_header;
    logic               w_last_data;
    logic               w_done;
    logic [CHUNK_W-1:0] w_chunk;
    logic [OCTET_W-1:0] w_octet;

    assign w_advance = !i_empty && (!r_out_valid || i_ready);
    assign w_header  = (r_slot == SLOT_SYNC) || (r_slot == SLOT_FIVE);
    assign w_last_data = (r_idx == i_job.n_data - 2'd1);

    always_comb begin
        case (r_idx)
            2'd0:    w_chunk = i_job.d0;
            2'd1:    w_chunk = i_job.d1;
            default: w_chunk = i_job.d2;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_octet = OCT_FILL;
        w_done  = 1'b0;
        case (r_state)
            ST_DATA: begin
                if (r_slot == SLOT_SYNC) begin
                    w_octet = OCT_SYNC;
                end else if (r_slot == SLOT_FIVE) begin
                    w_octet = OCT_FIVE;
                end else begin
                    w_octet = {w_chunk, 1'b1};
                    w_done  = w_last_data && (!i_job.eom || r_slot == SLOT_LAST);
                end
            end
            ST_FILL: begin
                w_octet = (r_slot == SLOT_FIVE) ? OCT_FIVE : OCT_FILL;
                w_done  = (r_slot == SLOT_LAST);
            end
            default: begin
                w_octet = OCT_FILL;
                w_done  = 1'b0;
            end
        endcase
    end

    // next state of the sequencer
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_slot  = r_slot;
        if (w_advance) begin
            n_slot = (r_slot == SLOT_LAST) ? SLOT_SYNC : r_slot + 1'b1;
            if (w_done) begin
                n_state = ST_DATA;
                n_idx   = '0;
            end else begin
                case (r_state)
                    ST_DATA: begin
                        if (!w_header) begin
                            if (w_last_data) begin
                                n_state = ST_FILL;
                            end else begin
                                n_idx = r_idx + 2'd1;
                            end
                        end
                    end
                    ST_FILL: n_state = ST_FILL;
                    default: n_state = ST_DATA;
                endcase
            end
        end
    end

    assign o_pop   = w_advance && w_done;
    assign o_valid = r_out_valid;
    assign o_octet = r_out_octet;
    assign o_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_octet <= w_octet;
            r_out_last  <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_DATA;
            r_slot      <= SLOT_SYNC;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_idx   <= n_idx;
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
